// ===== hdl/npme_pkg.sv =====
// Shared constants for the note probability to MIDI event block.
package npme_pkg;

  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned POS_W   = 27;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned SR_W    = 18;
  localparam int unsigned HOP_W   = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;

  localparam logic CMD_PROB  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic EV_ON  = 1'b0;
  localparam logic EV_OFF = 1'b1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd16384;
  localparam logic [HOP_W-1:0] HOP_RESET       = 12'd441;

  localparam logic [VEL_W-1:0] VEL_MAX   = 7'd127;
  localparam logic [6:0]       VEL_SCALE = 7'd127;
  localparam logic [POS_W-1:0] POS_MAX   = 27'h7FFFFFF;

  // floor(x / 100) for 18-bit x as (x * HOP_RECIP) >> HOP_SHIFT.
  localparam int unsigned      HOP_SHIFT = 25;
  localparam logic [18:0]      HOP_RECIP = 19'd335545;

endpackage

// ===== hdl/npme_note_mem.sv =====
// One-bit note state memory with registered read and per-entry valid bits.
module npme_note_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data
);

  logic             mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= vld[rd_addr] & mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

endmodule

// ===== hdl/note_probability_to_midi_events.sv =====
// Top level: thresholds note probabilities into MIDI note-on and note-off events.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   cmd, note, frame, probability
//   out      output     out_valid / out_ready event_kind, event_note, velocity, sample_pos
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Requests pass the first stage and the output register; one is accepted every cycle
// unless the output stalls. The note state memory is read on acceptance and written as it
// leaves the first stage, with the pending write forwarded to a request that reads the
// same note. Reset clears all note states at once through per-note valid bits; no sweep
// is needed. A stalled output holds the second stage, which then holds the input side.
module note_probability_to_midi_events #(
  parameter int unsigned NUM_NOTES = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [npme_pkg::NOTE_W-1:0]       note,
  input  logic [npme_pkg::FRAME_W-1:0]      frame,
  input  logic [npme_pkg::PROB_W-1:0]       probability,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              event_kind,
  output logic [npme_pkg::NOTE_W-1:0]       event_note,
  output logic [npme_pkg::VEL_W-1:0]        velocity,
  output logic [npme_pkg::POS_W-1:0]        sample_pos,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [npme_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned AW = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;

  logic [npme_pkg::THR_W-1:0] threshold;
  logic [npme_pkg::HOP_W-1:0] hop;
  logic [36:0]                hop_prod;

  logic                              s1_valid;
  logic                              s1_cmd;
  logic [npme_pkg::NOTE_W-1:0]       s1_note;
  logic [npme_pkg::FRAME_W-1:0]      s1_frame;
  logic [npme_pkg::PROB_W-1:0]       s1_prob;
  logic                              s1_inrange;
  logic                              s1_fwd_valid;
  logic                              s1_fwd_val;

  logic        accept;
  logic        in_range;
  logic        s1_fire;
  logic        rd_data;
  logic        cur_state;
  logic        want_on;
  logic        new_state;
  logic        ev_fire;
  logic        ev_kind;
  logic        wr_en;
  logic [22:0] vel_prod;
  logic [7:0]  vel_raw;
  logic [npme_pkg::VEL_W-1:0] vel_sat;
  logic [27:0] pos_prod;
  logic [npme_pkg::POS_W-1:0] pos_sat;

  assign cfg_ready = 1'b1;
  assign hop_prod  = 37'(cfg_data) * 37'(npme_pkg::HOP_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= npme_pkg::THRESHOLD_RESET;
      hop       <= npme_pkg::HOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        npme_pkg::REG_THRESHOLD:   threshold <= cfg_data[npme_pkg::THR_W-1:0];
        npme_pkg::REG_SAMPLE_RATE: hop <= hop_prod[npme_pkg::HOP_SHIFT +: npme_pkg::HOP_W];
        default: ;
      endcase
    end
  end

  assign in_range = ({1'b0, note} < 8'(NUM_NOTES));
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign accept   = in_valid && in_ready;

  assign cur_state = s1_fwd_valid ? s1_fwd_val : rd_data;
  assign want_on   = s1_prob > threshold;
  assign new_state = (s1_cmd == npme_pkg::CMD_FLUSH) ? 1'b0 : want_on;
  assign ev_fire   = s1_inrange &&
                     ((s1_cmd == npme_pkg::CMD_FLUSH) ? cur_state : (want_on != cur_state));
  assign ev_kind   = ((s1_cmd == npme_pkg::CMD_FLUSH) || !want_on) ?
                     npme_pkg::EV_OFF : npme_pkg::EV_ON;
  assign wr_en     = s1_fire && s1_inrange;

  assign vel_prod = 23'(s1_prob) * 23'(npme_pkg::VEL_SCALE);
  assign vel_raw  = vel_prod[22:15];
  assign vel_sat  = (vel_raw > 8'(npme_pkg::VEL_MAX)) ? npme_pkg::VEL_MAX
                                                      : vel_raw[npme_pkg::VEL_W-1:0];
  assign pos_prod = 28'(s1_frame) * 28'(hop);
  assign pos_sat  = pos_prod[27] ? npme_pkg::POS_MAX : pos_prod[npme_pkg::POS_W-1:0];

  npme_note_mem #(
    .DEPTH (NUM_NOTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_addr (note[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_note[AW-1:0]),
    .wr_data (new_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd       <= cmd;
      s1_note      <= note;
      s1_frame     <= frame;
      s1_prob      <= probability;
      s1_inrange   <= in_range;
      s1_fwd_valid <= wr_en && (s1_note == note);
      s1_fwd_val   <= new_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= ev_fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && ev_fire) begin
      event_kind <= ev_kind;
      event_note <= s1_note;
      velocity   <= (ev_kind == npme_pkg::EV_ON) ? vel_sat : '0;
      sample_pos <= pos_sat;
    end
  end

endmodule

// ===== hdl/npme_checker.sv =====
// Port-level checker for the note probability to MIDI event block, with its bind.
module npme_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              event_kind,
  input logic [npme_pkg::NOTE_W-1:0]       event_note,
  input logic [npme_pkg::VEL_W-1:0]        velocity,
  input logic [npme_pkg::POS_W-1:0]        sample_pos
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(event_note) && $stable(velocity) && $stable(sample_pos))
    else $error("Output request changed while stalled.");

  a_off_velocity: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == npme_pkg::EV_OFF) |-> velocity == '0)
    else $error("Note-off request carries a nonzero velocity.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Pipeline not empty after reset.");

endmodule

bind note_probability_to_midi_events npme_checker u_npme_checker (.*);
